[design/lcbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared constants and types for the LRU cluster buffer cache.
// ----------------------------------------------------------------------------
package lcbc_pkg;
  localparam int DEFAULT_ENTRIES = 16;
  localparam int TAG_W = 28;
  localparam int BUF_W = 4;
  localparam int CNT_W = 5;
  localparam logic [TAG_W-1:0] EMPTY_TAG = 28'hfffffff;
  localparam logic [TAG_W-1:0] CLUSTER_MIN = 28'd2;
  localparam logic [TAG_W-1:0] CLUSTER_LIMIT = 28'hffffff7;
  localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;

  typedef struct packed {
    logic [TAG_W-1:0] cluster;
    logic fill;
    logic write_intent;
  } req_t;

  typedef struct packed {
    logic status;
    logic [BUF_W-1:0] buffer_id;
    logic hit;
    logic writeback;
    logic [TAG_W-1:0] writeback_cluster;
    logic fill_read;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOVE,
    ST_OUT
  } state_t;
endpackage

[design/lcbc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_req_if, lcbc_rsp_if, lcbc_cfg_if
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface lcbc_req_if import lcbc_pkg::*; ();
  logic valid;
  logic ready;
  logic [TAG_W-1:0] cluster;
  logic fill;
  logic write_intent;
  modport source (output valid, cluster, fill, write_intent, input ready);
  modport sink (input valid, cluster, fill, write_intent, output ready);
endinterface

interface lcbc_rsp_if import lcbc_pkg::*; ();
  logic valid;
  logic ready;
  logic status;
  logic [BUF_W-1:0] buffer_id;
  logic hit;
  logic writeback;
  logic [TAG_W-1:0] writeback_cluster;
  logic fill_read;
  modport source (output valid, status, buffer_id, hit, writeback, writeback_cluster,
                  fill_read, input ready);
  modport sink (input valid, status, buffer_id, hit, writeback, writeback_cluster,
                fill_read, output ready);
endinterface

interface lcbc_cfg_if import lcbc_pkg::*; ();
  logic valid;
  logic ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/lru_cluster_buffer_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cluster_buffer_cache
// Move-to-front list of cluster buffers held in a slot memory plus an order list.
// ----------------------------------------------------------------------------
// A valid request passes through the look, move and output states after acceptance;
// its result is registered as the output state ends. A new request is not accepted
// until the previous result has been taken. Rejected requests skip those states
// and answer in the next cycle.
// Reset clears control state and the recency list; slot tags,
// dirty marks and the active count return to their reset values.
module lru_cluster_buffer_cache import lcbc_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input logic clk,
  input logic rst,
  lcbc_req_if.sink req,
  lcbc_rsp_if.source rsp,
  lcbc_cfg_if.sink cfg
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Order list: position -> slot. Tags, dirty marks and buffer ids live per slot.
  logic [IW-1:0] order [ENTRIES];
  logic [TAG_W-1:0] tags [ENTRIES];
  logic dirty [ENTRIES];
  logic [CNT_W-1:0] active;
  state_t state, state_next;
  req_t cur;
  rsp_t out;
  logic [IW-1:0] pos, slot;
  logic [TAG_W-1:0] old_tag;
  logic old_dirty, found;

  logic [CNT_W-1:0] n;
  always_comb begin
    n = active;
    if (n == '0) n = CNT_W'(1);
    if (int'(n) > ENTRIES) n = CNT_W'(ENTRIES);
  end

  wire bad = (req.cluster < CLUSTER_MIN) || (req.cluster >= CLUSTER_LIMIT);
  assign req.ready = (state == ST_IDLE) && !rsp.valid && !cfg.valid;
  assign cfg.ready = (state == ST_IDLE);

  // Parallel tag compare over the active positions.
  logic [IW-1:0] hpos, epos;
  logic hfound, efound;
  always_comb begin
    hpos = '0; epos = '0; hfound = 1'b0; efound = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (i < int'(n)) begin
        if (tags[order[i]] == cur.cluster) begin
          hfound = 1'b1; hpos = IW'(i);
        end
        if (tags[order[i]] == EMPTY_TAG) begin
          efound = 1'b1; epos = IW'(i);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid && req.ready && !bad) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_MOVE;
      ST_MOVE: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp.valid <= 1'b0;
      active <= ACTIVE_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        order[i] <= IW'(i);
        tags[i] <= EMPTY_TAG;
        dirty[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) active <= cfg.data;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (req.valid && req.ready) begin
          cur <= req_t'{req.cluster, req.fill, req.write_intent};
          if (bad) begin
            out <= '{status: 1'b1, default: '0};
            rsp.valid <= 1'b1;
          end
        end
        ST_LOOK: begin
          found <= hfound;
          pos <= hfound ? hpos : (efound ? epos : IW'(n - CNT_W'(1)));
          slot <= order[hfound ? hpos : (efound ? epos : IW'(n - CNT_W'(1)))];
        end
        ST_MOVE: begin
          old_tag <= tags[slot];
          old_dirty <= dirty[slot];
          for (int i = 1; i < ENTRIES; i++)
            if (IW'(i) <= pos) order[i] <= order[i-1];
          order[0] <= slot;
          tags[slot] <= cur.cluster;
          dirty[slot] <= cur.write_intent | (found & dirty[slot]);
        end
        ST_OUT: begin
          out.status <= 1'b0;
          out.buffer_id <= BUF_W'(slot);
          out.hit <= found;
          out.writeback <= !found && old_tag != EMPTY_TAG && old_dirty;
          out.writeback_cluster <= (!found && old_tag != EMPTY_TAG && old_dirty)
                                   ? old_tag : '0;
          out.fill_read <= !found && cur.fill;
          rsp.valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rsp.status = out.status;
  assign rsp.buffer_id = out.buffer_id;
  assign rsp.hit = out.hit;
  assign rsp.writeback = out.writeback;
  assign rsp.writeback_cluster = out.writeback_cluster;
  assign rsp.fill_read = out.fill_read;

  a_wb_miss: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && (rsp.writeback || rsp.fill_read)))
    else $error("hit with miss work");
  a_rej: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.buffer_id == '0 && !rsp.hit))
    else $error("reject payload");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req.ready) else $error("ready while busy");
endmodule
